### rtl/core/dfbc_pkg.sv
// Shared types and constants for the directional focus best-candidate selector.
`timescale 1ns / 1ps

package dfbc_pkg;

	// Coordinate width; the port structs below are built on it.
	localparam int COORD_WIDTH = 16;
	localparam int ID_WIDTH    = 16;
	localparam int DIR_W       = 3;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = COORD_WIDTH;

	localparam logic [CFG_INDEX_W-1:0] REG_NODE_LEFT   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NODE_TOP    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NODE_RIGHT  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_NODE_BOTTOM = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_DIR  = 3'd4;

	// Search direction codes; any other code never yields a candidate
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;

	// Weight on the squared major gap: 13, scaled by 4 with the minor term
	localparam int MAJOR_WEIGHT = 52;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} box_t;

	// Input beat
	typedef struct packed {
		coord_t                cand_left;
		coord_t                cand_top;
		coord_t                cand_right;
		coord_t                cand_bottom;
		logic [ID_WIDTH-1:0]   cand_id;
		logic                  last_cand;
	} cand_t;

	// Output beat
	typedef struct packed {
		logic                  took_new;
		logic [ID_WIDTH-1:0]   best_id;
		logic                  found;
		logic                  search_done;
	} result_t;

endpackage

### rtl/core/directional_focus_best_candidate.sv
// An accepted input beat passes through the input register and then the result register.
// Throughput: one candidate per cycle unless the result stalls; the candidate and the registered
// best are both scored against the focused rectangle and compared in a single pass ahead of the
// result register. Reset (arst_n low, asynchronous): focused rectangle and direction go to zero,
// running best is cleared, both pipeline slots empty.
`timescale 1ns / 1ps

module directional_focus_best_candidate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  dfbc_pkg::cand_t                     in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output dfbc_pkg::result_t                   out_data,
	input  logic                                cfg_we,
	input  logic [dfbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dfbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dfbc_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int GW   = CW + 1;          // edge difference
	localparam int MW   = CW + 2;          // difference of edge sums
	localparam int MA_W = 2 * CW;          // squared major gap
	localparam int MI_W = 2 * (CW + 1);    // squared minor difference
	localparam int WW   = 2 * CW + 7;      // 52*major^2 + minor^2, exact

	// Per-rectangle scores against the focused rectangle
	typedef struct packed {
		logic            qual;
		logic            beam;
		logic            beyond;
		logic [CW-1:0]   near;
		logic [CW-1:0]   far;
		logic [WW-1:0]   weight;
	} score_t;

	function automatic score_t score_box(box_t n, box_t c, logic [DIR_W-1:0] d);
		logic signed [GW-1:0] nl, nt, nr, nb, cl, ct, cr, cb;
		logic signed [GW-1:0] ng, fg;
		logic signed [MW-1:0] ms, ms_abs;
		logic [CW:0]          minor_m;
		logic [MA_W-1:0]      ma;
		logic [MI_W-1:0]      mi;
		score_t               s;
		nl = GW'($signed(n.left));
		nt = GW'($signed(n.top));
		nr = GW'($signed(n.right));
		nb = GW'($signed(n.bottom));
		cl = GW'($signed(c.left));
		ct = GW'($signed(c.top));
		cr = GW'($signed(c.right));
		cb = GW'($signed(c.bottom));
		s  = '0;
		ng = '0;
		fg = '0;
		ms = '0;
		unique case (d)
			DIR_UP: begin
				s.qual   = (nt > ct) && (nb > cb);
				s.beam   = (nl < cr) && (cl < nr);
				s.beyond = (nt >= cb);
				ng = nt - cb;
				fg = nt - ct;
				ms = (MW'(nl) + MW'(nr)) - (MW'(cl) + MW'(cr));
			end
			DIR_DOWN: begin
				s.qual   = (nt < ct) && (nb < cb);
				s.beam   = (nl < cr) && (cl < nr);
				s.beyond = (nb <= ct);
				ng = ct - nb;
				fg = cb - nb;
				ms = (MW'(nl) + MW'(nr)) - (MW'(cl) + MW'(cr));
			end
			DIR_LEFT: begin
				s.qual   = (nl > cl) && (nr > cr);
				s.beam   = (nt < cb) && (ct < nb);
				s.beyond = (nl >= cr);
				ng = nl - cr;
				fg = nl - cl;
				ms = (MW'(nt) + MW'(nb)) - (MW'(ct) + MW'(cb));
			end
			DIR_RIGHT: begin
				s.qual   = (nl < cl) && (nr < cr);
				s.beam   = (nt < cb) && (ct < nb);
				s.beyond = (nr <= cl);
				ng = cl - nr;
				fg = cr - nr;
				ms = (MW'(nt) + MW'(nb)) - (MW'(ct) + MW'(cb));
			end
			default: begin
				s.qual = 1'b0;
			end
		endcase
		// near gap clamps at zero, far gap at one
		s.near  = ng[GW-1] ? '0 : ng[CW-1:0];
		s.far   = (ng[GW-1] || fg[GW-1] || fg == '0) && (fg[GW-1] || fg == '0)
			? CW'(1) : fg[CW-1:0];
		ms_abs  = ms[MW-1] ? -ms : ms;
		minor_m = ms_abs[CW:0];
		ma      = MA_W'(s.near) * MA_W'(s.near);
		mi      = MI_W'(minor_m) * MI_W'(minor_m);
		s.weight = WW'(ma) * WW'(MAJOR_WEIGHT) + WW'(mi);
		return s;
	endfunction

	// Configuration registers
	box_t             node_q;
	logic [DIR_W-1:0] dir_q;

	// Input stage
	logic             valid_s1;
	box_t             cand_s1;
	logic [ID_WIDTH-1:0] id_s1;
	logic             last_s1;

	// Running best
	box_t             best_q;
	logic [ID_WIDTH-1:0] best_id_q;
	logic             have_best_q;

	// Result register
	logic             out_valid_q;
	result_t          out_q;

	score_t           sc_cand;
	score_t           sc_best;
	logic             horiz;
	logic             cand_outright;
	logic             best_outright;
	logic             took;
	logic             advance;

	// Handshake: the input stage moves on whenever the result slot is free or draining
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Compare candidate against the running best
	always_comb begin
		sc_cand = score_box(node_q, cand_s1, dir_q);
		sc_best = score_box(node_q, best_q, dir_q);
		horiz   = (dir_q == DIR_LEFT) || (dir_q == DIR_RIGHT);
		cand_outright = !sc_best.beam && sc_cand.beam
			&& (!sc_best.beyond || horiz || (sc_cand.near < sc_best.far));
		best_outright = !sc_cand.beam && sc_best.beam
			&& (!sc_cand.beyond || horiz || (sc_best.near < sc_cand.far));
		took = sc_cand.qual && (!have_best_q || !sc_best.qual || cand_outright
			|| (!best_outright && (sc_cand.weight < sc_best.weight)));
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
			dir_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NODE_LEFT:   node_q.left   <= coord_t'(cfg_data);
				REG_NODE_TOP:    node_q.top    <= coord_t'(cfg_data);
				REG_NODE_RIGHT:  node_q.right  <= coord_t'(cfg_data);
				REG_NODE_BOTTOM: node_q.bottom <= coord_t'(cfg_data);
				REG_SEARCH_DIR:  dir_q         <= cfg_data[DIR_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline control and running best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			best_q      <= '0;
			best_id_q   <= '0;
			have_best_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (last_s1) begin
					// search ends: drop the running best after this result
					best_q      <= '0;
					best_id_q   <= '0;
					have_best_q <= 1'b0;
				end else if (took) begin
					best_q      <= cand_s1;
					best_id_q   <= id_s1;
					have_best_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cand_s1.left   <= in_data.cand_left;
			cand_s1.top    <= in_data.cand_top;
			cand_s1.right  <= in_data.cand_right;
			cand_s1.bottom <= in_data.cand_bottom;
			id_s1          <= in_data.cand_id;
			last_s1        <= in_data.last_cand;
		end
		if (advance) begin
			out_q.took_new    <= took;
			out_q.best_id     <= took ? id_s1 : best_id_q;
			out_q.found       <= took || have_best_q;
			out_q.search_done <= last_s1;
		end
	end

endmodule

### rtl/core/dfbc_checker.sv
// Port-level checks for the best-candidate selector, bound to the top level.
`timescale 1ns / 1ps

module dfbc_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_ready,
	input  dfbc_pkg::result_t   out_data
);
	import dfbc_pkg::*;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// Taking a candidate always leaves a best
	a_took_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.took_new |-> out_data.found)
		else $error("took_new without found");

	// No best reports id zero
	a_empty_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.best_id == '0)
		else $error("best_id nonzero with nothing found");

	// First result after a finished search starts from an empty best
	a_fresh_search: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid && out_ready && out_data.search_done)
		|-> out_data.found == out_data.took_new)
		else $error("running best survived end of search");

endmodule

bind directional_focus_best_candidate dfbc_checker u_dfbc_checker (.*);
